### design/lpsm_pkg.sv
`timescale 1ns / 1ps

package lpsm_pkg;

    // Table geometry
    localparam int LOGICAL_DEPTH = 4096;
    localparam int ADDR_W        = $clog2(LOGICAL_DEPTH);
    localparam int ID_W          = 12;
    localparam int SLOT_W        = 12;
    localparam int CNT_W         = 13;
    localparam int ENTRY_W       = SLOT_W + 1;
    localparam int VALID_POS     = SLOT_W;

    // Capacity ceiling: the table depth, never beyond what a 12-bit id reaches
    localparam int CAP_LIMIT_INT = (LOGICAL_DEPTH < 4096) ? LOGICAL_DEPTH : 4096;
    localparam logic [CNT_W-1:0]  CAP_LIMIT   = CNT_W'(CAP_LIMIT_INT);
    localparam logic [CNT_W-1:0]  CAP_RESET   = CNT_W'(4096);
    localparam logic [ADDR_W:0]   SWEEP_END   = (ADDR_W + 1)'(LOGICAL_DEPTH);

    typedef enum logic [2:0] {
        CMD_ALLOCATE = 3'd0,
        CMD_PUBLISH  = 3'd1,
        CMD_REBIND   = 3'd2,
        CMD_REMOVE   = 3'd3,
        CMD_MOVE     = 3'd4,
        CMD_COMPACT  = 3'd5,
        CMD_RESOLVE  = 3'd6,
        CMD_CLEAR    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ID_RANGE   = 3'd1,
        ST_BOUND      = 3'd2,
        ST_UNBOUND    = 3'd3,
        ST_SLOT_RANGE = 3'd4
    } status_t;

    // Table port request from the sequencer
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } mem_req_t;

    // Finished command result, valid for one cycle
    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  phys;
        logic [CNT_W-1:0]  bound;
    } result_t;

    // Map a 12-bit id onto a table address
    function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
        return ADDR_W'(id);
    endfunction

endpackage

### design/lpsm_ram.sv
`timescale 1ns / 1ps

module lpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/lpsm_core.sv
`timescale 1ns / 1ps

module lpsm_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  lpsm_pkg::cmd_t                  command,
    input  logic [lpsm_pkg::ID_W-1:0]       logical_id,
    input  logic [lpsm_pkg::ID_W-1:0]       target_id,
    input  logic [lpsm_pkg::SLOT_W-1:0]     slot_operand,
    input  logic [lpsm_pkg::CNT_W-1:0]      capacity,
    input  logic [lpsm_pkg::ENTRY_W-1:0]    rd_data,
    output lpsm_pkg::mem_req_t              mem_req,
    output lpsm_pkg::result_t               res,
    output logic                            idle
);

    import lpsm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_LOOK2 = 5'b00100,
        S_MVWR  = 5'b01000,
        S_SWEEP = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [ID_W-1:0]     tgt_reg, tgt_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [ENTRY_W-1:0]  src_reg, src_next;
    logic [CNT_W-1:0]    phys_reg, phys_next;
    logic [CNT_W-1:0]    bound_reg, bound_next;
    logic [ADDR_W:0]     swp_cnt_reg, swp_cnt_next;
    logic                swp_pend_reg, swp_pend_next;
    logic [ADDR_W-1:0]   swp_addr_reg, swp_addr_next;
    logic                swp_compact_reg, swp_compact_next;
    logic                swp_reply_reg, swp_reply_next;

    logic                id_ok;
    logic                tgt_ok;
    logic                entry_valid;
    logic                slot_ok;
    logic                finish;
    status_t             status_sel;
    logic [SLOT_W-1:0]   slot_sel;

    // Checks shared by the lookup arms
    assign id_ok       = {1'b0, id_reg} < capacity;
    assign tgt_ok      = {1'b0, tgt_reg} < capacity;
    assign entry_valid = rd_data[VALID_POS];
    assign slot_ok     = {1'b0, slot_reg} < phys_reg;
    assign idle        = (state_reg == S_IDLE);

    // Sequencer: lookup, modify, write back, and whole-table sweeps
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        tgt_next         = tgt_reg;
        slot_next        = slot_reg;
        src_next         = src_reg;
        phys_next        = phys_reg;
        bound_next       = bound_reg;
        swp_cnt_next     = swp_cnt_reg;
        swp_pend_next    = swp_pend_reg;
        swp_addr_next    = swp_addr_reg;
        swp_compact_next = swp_compact_reg;
        swp_reply_next   = swp_reply_reg;
        mem_req          = '0;
        finish           = 1'b0;
        status_sel       = ST_OK;
        slot_sel         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the word and start the lookup of the id
                if (start)
                begin
                    cmd_next        = command;
                    id_next         = logical_id;
                    tgt_next        = target_id;
                    slot_next       = slot_operand;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = to_addr(logical_id);
                    state_next      = S_LOOK;
                end
            end

            S_LOOK:
            begin
                finish = 1'b1;
                unique case (cmd_reg)
                    CMD_ALLOCATE:
                    begin
                        if (phys_reg >= capacity)
                        begin
                            status_sel = ST_ID_RANGE;
                        end
                        else
                        begin
                            slot_sel  = phys_reg[SLOT_W-1:0];
                            phys_next = phys_reg + CNT_W'(1);
                        end
                    end

                    CMD_PUBLISH, CMD_REBIND:
                    begin
                        priority if (!slot_ok)
                        begin
                            status_sel = ST_SLOT_RANGE;
                        end
                        else if (!id_ok)
                        begin
                            status_sel = ST_ID_RANGE;
                        end
                        else if (cmd_reg == CMD_PUBLISH && entry_valid)
                        begin
                            status_sel = ST_BOUND;
                        end
                        else if (cmd_reg == CMD_REBIND && !entry_valid)
                        begin
                            status_sel = ST_UNBOUND;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = to_addr(id_reg);
                            mem_req.wr_data = {1'b1, slot_reg};
                            if (cmd_reg == CMD_PUBLISH)
                            begin
                                bound_next = bound_reg + CNT_W'(1);
                            end
                        end
                    end

                    CMD_REMOVE, CMD_MOVE:
                    begin
                        priority if (cmd_reg == CMD_MOVE && id_reg != tgt_reg)
                        begin
                            // Source checked here, target read next
                            priority if (!id_ok || !tgt_ok)
                            begin
                                status_sel = ST_ID_RANGE;
                            end
                            else if (!entry_valid)
                            begin
                                status_sel = ST_UNBOUND;
                            end
                            else
                            begin
                                finish          = 1'b0;
                                src_next        = rd_data;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = to_addr(tgt_reg);
                                state_next      = S_LOOK2;
                            end
                        end
                        else if (!id_ok)
                        begin
                            status_sel = ST_ID_RANGE;
                        end
                        else if (!entry_valid)
                        begin
                            status_sel = ST_UNBOUND;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = to_addr(id_reg);
                            mem_req.wr_data = '0;
                            bound_next      = bound_reg - CNT_W'(1);
                        end
                    end

                    CMD_COMPACT:
                    begin
                        if (!slot_ok)
                        begin
                            status_sel = ST_SLOT_RANGE;
                        end
                        else
                        begin
                            finish           = 1'b0;
                            swp_cnt_next     = '0;
                            swp_compact_next = 1'b1;
                            swp_reply_next   = 1'b1;
                            state_next       = S_SWEEP;
                        end
                    end

                    CMD_RESOLVE:
                    begin
                        priority if (!id_ok)
                        begin
                            status_sel = ST_ID_RANGE;
                        end
                        else if (!entry_valid)
                        begin
                            status_sel = ST_UNBOUND;
                        end
                        else
                        begin
                            slot_sel = rd_data[SLOT_W-1:0];
                        end
                    end

                    CMD_CLEAR:
                    begin
                        finish           = 1'b0;
                        swp_cnt_next     = '0;
                        swp_compact_next = 1'b0;
                        swp_reply_next   = 1'b1;
                        state_next       = S_SWEEP;
                    end

                    default:
                    begin
                        status_sel = ST_OK;
                    end
                endcase
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end

            S_LOOK2:
            begin
                // Target entry arrives: copy the source binding over it, or report unbound if it is empty
                if (!entry_valid)
                begin
                    finish     = 1'b1;
                    status_sel = ST_UNBOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = to_addr(tgt_reg);
                    mem_req.wr_data = src_reg;
                    state_next      = S_MVWR;
                end
            end

            S_MVWR:
            begin
                // Unbind the source
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = to_addr(id_reg);
                mem_req.wr_data = '0;
                bound_next      = bound_reg - CNT_W'(1);
                finish          = 1'b1;
                state_next      = S_IDLE;
            end

            S_SWEEP:
            begin
                // Issue one entry a cycle: read for compact, zero for clear
                swp_pend_next = 1'b0;
                if (swp_cnt_reg < SWEEP_END)
                begin
                    swp_cnt_next = swp_cnt_reg + (ADDR_W + 1)'(1);
                    if (swp_compact_reg)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = swp_cnt_reg[ADDR_W-1:0];
                        swp_pend_next   = 1'b1;
                        swp_addr_next   = swp_cnt_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = swp_cnt_reg[ADDR_W-1:0];
                        mem_req.wr_data = '0;
                    end
                end

                // Rewrite the entry read last cycle, shifted down, if it is bound and above the gap
                if (swp_pend_reg && entry_valid && rd_data[SLOT_W-1:0] > slot_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = swp_addr_reg;
                    mem_req.wr_data = rd_data - ENTRY_W'(1);
                end

                // Walk done
                if (swp_cnt_reg == SWEEP_END && !swp_pend_reg)
                begin
                    if (swp_compact_reg)
                    begin
                        phys_next = phys_reg - CNT_W'(1);
                    end
                    else
                    begin
                        phys_next  = '0;
                        bound_next = '0;
                    end
                    finish         = swp_reply_reg;
                    swp_reply_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.valid  = finish;
        res.status = status_sel;
        res.slot   = (status_sel == ST_OK) ? slot_sel : '0;
        res.phys   = phys_next;
        res.bound  = bound_next;
    end

    // Control state; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            phys_reg        <= '0;
            bound_reg       <= '0;
            swp_cnt_reg     <= '0;
            swp_pend_reg    <= 1'b0;
            swp_compact_reg <= 1'b0;
            swp_reply_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phys_reg        <= phys_next;
            bound_reg       <= bound_next;
            swp_cnt_reg     <= swp_cnt_next;
            swp_pend_reg    <= swp_pend_next;
            swp_compact_reg <= swp_compact_next;
            swp_reply_reg   <= swp_reply_next;
        end
    end

    // Operand holding registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        tgt_reg      <= tgt_next;
        slot_reg     <= slot_next;
        src_reg      <= src_next;
        swp_addr_reg <= swp_addr_next;
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("command started while busy");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_req.wr_en)
        else $error("table written while idle");

    a_result_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> state_reg == S_IDLE)
        else $error("result given without returning to idle");

    a_phys_limit: assert property (@(posedge clk) disable iff (!rst_n)
        phys_reg <= CAP_LIMIT && bound_reg <= CNT_W'(LOGICAL_DEPTH))
        else $error("count above table limit");

    a_sweep_pend: assert property (@(posedge clk) disable iff (!rst_n)
        swp_pend_reg |-> state_reg == S_SWEEP && swp_compact_reg)
        else $error("sweep write-back outside compact walk");

endmodule

### design/logical_to_physical_slot_map.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid / in_ready        command, logical_id, target_id, slot_operand
// output    out_valid / out_ready      status, slot_out, physical_total, bound_total
// config    cfg_wr_en                  cfg_wr_data (logical_capacity)
//
// Allocate, publish, rebind, remove and resolve read the table, then decide and
// write back. Move ends after the first read on an id or source error, after the
// target read when the target is unbound, else does a second read and two writes.
// Compact and clear walk all LOGICAL_DEPTH entries through the one table port; a
// compact with its slot out of range ends after the first read.
// After reset a clearing pass over all entries runs with in_ready low.
// A result waits in the output register; the next word is taken as soon as that
// register is free or being drained.

module logical_to_physical_slot_map (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     command,
    input  logic [lpsm_pkg::ID_W-1:0]      logical_id,
    input  logic [lpsm_pkg::ID_W-1:0]      target_id,
    input  logic [lpsm_pkg::SLOT_W-1:0]    slot_operand,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     status,
    output logic [lpsm_pkg::SLOT_W-1:0]    slot_out,
    output logic [lpsm_pkg::CNT_W-1:0]     physical_total,
    output logic [lpsm_pkg::CNT_W-1:0]     bound_total,
    input  logic                           cfg_wr_en,
    input  logic [lpsm_pkg::CNT_W-1:0]     cfg_wr_data
);

    import lpsm_pkg::*;

    logic [CNT_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   capacity;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CNT_W-1:0]   phys_reg;
    logic [CNT_W-1:0]   bound_reg;
    logic               core_idle;
    logic               start;
    mem_req_t           mem_req;
    result_t            res;
    logic [ENTRY_W-1:0] rd_data;

    // Clamp the programmed capacity to what the table holds
    assign capacity = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;

    assign in_ready = core_idle && (!out_valid_reg || out_ready);
    assign start    = in_valid && in_ready;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Output word valid: load on result, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg <= res.status;
            slot_reg   <= res.slot;
            phys_reg   <= res.phys;
            bound_reg  <= res.bound;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign slot_out       = slot_reg;
    assign physical_total = phys_reg;
    assign bound_total    = bound_reg;

    lpsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOGICAL_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    lpsm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (cmd_t'(command)),
        .logical_id   (logical_id),
        .target_id    (target_id),
        .slot_operand (slot_operand),
        .capacity     (capacity),
        .rd_data      (rd_data),
        .mem_req      (mem_req),
        .res          (res),
        .idle         (core_idle)
    );

endmodule
